>>> rtl/cslc_pkg.sv
// ----------------------------------------------------------------------------
// cslc_pkg
// shared types and constants for the centred same-length convolution core
// ----------------------------------------------------------------------------
package cslc_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int COEF_BITS    = 16;
	localparam int RESULT_BITS  = 34;
	localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
	localparam int DEF_MAX_TAPS = 7;

	localparam int TCNT_BITS    = 3;
	localparam int DLY_BITS     = 2;
	localparam int SEEN_BITS    = 3;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = COEF_BITS;

	localparam logic [SEEN_BITS-1:0]    SEEN_MAX      = 3'd7;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = 3'd7;
	localparam logic [TCNT_BITS-1:0]    TCNT_RESET    = 3'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [RESULT_BITS-1:0] acc_t;

	typedef struct packed {
		sample_t sample;
		logic    final_sample;
	} in_word_t;

	typedef struct packed {
		acc_t result_value;
		logic final_result;
	} out_word_t;

	// one shift of the sample window
	typedef struct packed {
		logic    fire;
		sample_t data;
		logic    emit;
		logic    last;
	} step_t;

	typedef enum logic {
		SEQ_RUN,
		SEQ_FLUSH
	} seq_state_t;

endpackage

>>> rtl/cslc_cell.sv
// ----------------------------------------------------------------------------
// cslc_cell
// one window position: holds a sample, passes it on and forms its product
// ----------------------------------------------------------------------------
module cslc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            clear,
	input  cslc_pkg::sample_t din,
	input  cslc_pkg::coef_t   tap,
	input  logic            tap_en,
	output cslc_pkg::sample_t win,
	output cslc_pkg::prod_t   prod
);
	import cslc_pkg::*;

	sample_t win_q;
	prod_t   prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= clear ? sample_t'(0) : din;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			prod_s1 <= tap_en ? prod_t'(din) * prod_t'(tap) : prod_t'(0);
		end
	end

	assign win  = win_q;
	assign prod = prod_s1;

endmodule

>>> rtl/cslc_seq.sv
// ----------------------------------------------------------------------------
// cslc_seq
// turns input words into window shifts, adding zero shifts after the last one when the delay is not zero
// ----------------------------------------------------------------------------
module cslc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  cslc_pkg::in_word_t            sample_word,
	input  logic                          s1_free,
	input  logic [cslc_pkg::DLY_BITS-1:0] delay,
	output cslc_pkg::step_t               step
);
	import cslc_pkg::*;

	localparam int CMP_BITS = SEEN_BITS + 1;

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [SEEN_BITS-1:0] seen_q;
	logic [DLY_BITS-1:0]  j_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_RUN: begin
				if (sample_valid && s1_free && sample_word.final_sample && delay != '0) begin
					state_d = SEQ_FLUSH;
				end
			end
			SEQ_FLUSH: begin
				if (s1_free && j_q == delay) begin
					state_d = SEQ_RUN;
				end
			end
			default: state_d = SEQ_RUN;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		step         = '0;
		unique case (state_q)
			SEQ_RUN: begin
				sample_ready = s1_free;
				step.fire    = sample_valid && s1_free;
				step.data    = sample_word.sample;
				step.emit    = seen_q >= SEEN_BITS'(delay);
				step.last    = sample_word.final_sample && delay == '0;
			end
			SEQ_FLUSH: begin
				step.fire = s1_free;
				step.data = '0;
				step.emit = (CMP_BITS'(seen_q) + CMP_BITS'(j_q)) >= CMP_BITS'(delay);
				step.last = j_q == delay;
			end
			default: begin
				sample_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_RUN;
			seen_q  <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (step.fire) begin
				if (step.last) begin
					seen_q <= '0;
				end else if (state_q == SEQ_RUN && !sample_word.final_sample
						&& seen_q != SEEN_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
				j_q <= (state_q == SEQ_RUN) ? DLY_BITS'(1) : j_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/cslc_sum.sv
// ----------------------------------------------------------------------------
// cslc_sum
// registered two-level adder tree over the cell products
// ----------------------------------------------------------------------------
module cslc_sum #(
	parameter int MAX_TAPS = cslc_pkg::DEF_MAX_TAPS
) (
	input  logic            clk,
	input  logic            en_s2,
	input  logic            en_out,
	input  cslc_pkg::prod_t prod [MAX_TAPS],
	output cslc_pkg::acc_t  result
);
	import cslc_pkg::*;

	localparam int NPAIR = (MAX_TAPS + 1) / 2;

	acc_t pair_s2 [NPAIR];
	acc_t result_q;

	for (genvar p = 0; p < NPAIR; p++) begin : g_pair
		if (2 * p + 1 < MAX_TAPS) begin : g_two
			always_ff @(posedge clk) begin
				if (en_s2) begin
					pair_s2[p] <= acc_t'(prod[2*p]) + acc_t'(prod[2*p+1]);
				end
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				if (en_s2) begin
					pair_s2[p] <= acc_t'(prod[2*p]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_t total;
		total = '0;
		for (int p = 0; p < NPAIR; p++) begin
			total = total + pair_s2[p];
		end
		if (en_out) begin
			result_q <= total;
		end
	end

	assign result = result_q;

endmodule

>>> rtl/centered_same_length_convolution_core.sv
// output: a result passes the product, pair-sum and output registers after the
//   window shift that completes it, d = taps-1-taps/2 samples after its sample
// throughput: one sample word per cycle unless the result side stalls; a word
//   marked final holds the input while d zeros are shifted through the cell row
// reset (asynchronous, active low): window, counters and valid bits clear,
//   taps read zero and the tap count one
// ----------------------------------------------------------------------------
// centered_same_length_convolution_core
// streaming fir over a row of tap cells, output length equal to input length
// ----------------------------------------------------------------------------
module centered_same_length_convolution_core #(
	parameter int MAX_TAPS = cslc_pkg::DEF_MAX_TAPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  cslc_pkg::in_word_t                sample_word,
	output logic                              result_valid,
	input  logic                              result_ready,
	output cslc_pkg::out_word_t               result_word,
	input  logic                              cfg_we,
	input  logic [cslc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [cslc_pkg::CFG_BITS-1:0]     cfg_data
);
	import cslc_pkg::*;

	coef_t                tap_q [MAX_TAPS];
	logic [TCNT_BITS-1:0] tap_count_q;
	logic [TCNT_BITS-1:0] taps_eff;
	logic [TCNT_BITS-1:0] delay_full;
	logic [DLY_BITS-1:0]  delay;

	step_t   step;
	sample_t win  [MAX_TAPS];
	prod_t   prod [MAX_TAPS];
	acc_t    sum;

	logic v_s1_q, last_s1_q;
	logic v_s2_q, last_s2_q;
	logic out_v_q, out_last_q;
	logic out_free, s2_free, s1_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				tap_q[k] <= '0;
			end
			tap_count_q <= TCNT_RESET;
		end else if (cfg_we) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				if (cfg_index == CFG_IDX_BITS'(k)) begin
					tap_q[k] <= coef_t'(cfg_data);
				end
			end
			if (cfg_index == CFG_TAP_COUNT) begin
				tap_count_q <= cfg_data[TCNT_BITS-1:0];
			end
		end
	end

	always_comb begin
		priority if (tap_count_q == '0) begin
			taps_eff = TCNT_BITS'(1);
		end else if (tap_count_q > TCNT_BITS'(MAX_TAPS)) begin
			taps_eff = TCNT_BITS'(MAX_TAPS);
		end else begin
			taps_eff = tap_count_q;
		end
	end

	assign delay_full = taps_eff - TCNT_BITS'(1) - (taps_eff >> 1);
	assign delay      = delay_full[DLY_BITS-1:0];

	// stage handshakes
	assign out_free = !out_v_q || result_ready;
	assign s2_free  = !v_s2_q || out_free;
	assign s1_free  = !v_s1_q || s2_free;

	cslc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.s1_free      (s1_free),
		.delay        (delay),
		.step         (step)
	);

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		cslc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (step.fire),
			.clear  (step.last),
			.din    ((k == 0) ? step.data : win[(k == 0) ? 0 : k-1]),
			.tap    (tap_q[k]),
			.tap_en (TCNT_BITS'(k) < taps_eff),
			.win    (win[k]),
			.prod   (prod[k])
		);
	end

	cslc_sum #(
		.MAX_TAPS (MAX_TAPS)
	) u_sum (
		.clk    (clk),
		.en_s2  (s2_free && v_s1_q),
		.en_out (out_free && v_s2_q),
		.prod   (prod),
		.result (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q     <= 1'b0;
			last_s1_q  <= 1'b0;
			v_s2_q     <= 1'b0;
			last_s2_q  <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1_q    <= step.fire && step.emit;
				last_s1_q <= step.last;
			end
			if (s2_free) begin
				v_s2_q    <= v_s1_q;
				last_s2_q <= last_s1_q;
			end
			if (out_free) begin
				out_v_q    <= v_s2_q;
				out_last_q <= last_s2_q;
			end
		end
	end

	assign result_valid             = out_v_q;
	assign result_word.result_value = sum;
	assign result_word.final_result = out_last_q;

`ifndef SYNTHESIS
	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && step.last |=> win[0] == '0)
		else $error("window not cleared after final word");

	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && sample_word.final_sample && delay != '0
		|=> !sample_ready)
		else $error("input taken during flush");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !s2_free |=> v_s1_q && $stable(last_s1_q))
		else $error("stage one word lost while stalled");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for centered_same_length_convolution_core: a model of
// the tap window predicts every result word from the accepted sample words
// and the current kernel; directed sequences cover reset taps, extreme
// values, zero and changing tap counts and one-sample sequences, then random
// kernels and sequences run under three patterns of idling on both channels
// ----------------------------------------------------------------------------
module tb;

	import cslc_pkg::*;

	localparam int N_TAPS    = DEF_MAX_TAPS;
	localparam int LAT_WAIT  = 12;
	localparam int RUN_LIMIT = 4_000_000;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    sample_valid = 1'b0;
	logic                    sample_ready;
	in_word_t                sample_word  = '0;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	out_word_t               result_word;
	logic                    cfg_we       = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic [CFG_BITS-1:0]     cfg_data     = '0;

	centered_same_length_convolution_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// model state
	coef_t                kernel [N_TAPS];
	logic [TCNT_BITS-1:0] kernel_len;
	sample_t              window [N_TAPS];
	int                   seen;

	out_word_t pending_results [$];
	out_word_t want;
	int        errors    = 0;
	int        send_idle = 0;
	int        recv_idle = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic acc_t window_sum(int t);
		longint acc;
		acc = 0;
		for (int k = 0; k < t; k++)
			acc += longint'(window[k]) * longint'(kernel[k]);
		return acc_t'(acc[RESULT_BITS-1:0]);
	endfunction

	function automatic void shift_window(sample_t s);
		for (int k = N_TAPS - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = s;
	endfunction

	task automatic convolve_sample(in_word_t w);
		int t;
		int d;
		int n;
		t = (kernel_len == 0) ? 1 : int'(kernel_len);
		if (t > N_TAPS)
			t = N_TAPS;
		d = t - 1 - t / 2;
		n = seen;
		shift_window(w.sample);
		if (!w.final_sample) begin
			if (n >= d)
				pending_results.push_back('{result_value: window_sum(t), final_result: 1'b0});
			if (seen < int'(SEEN_MAX))
				seen++;
		end else begin
			for (int j = 0; j <= d; j++) begin
				if (j > 0)
					shift_window('0);
				if (n + j >= d)
					pending_results.push_back('{result_value: window_sum(t), final_result: 1'b0});
			end
			pending_results[pending_results.size()-1].final_result = 1'b1;
			for (int k = 0; k < N_TAPS; k++)
				window[k] = '0;
			seen = 0;
		end
	endtask

	task automatic push_sample(sample_t s, logic fin);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= '{sample: s, final_sample: fin};
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		convolve_sample('{sample: s, final_sample: fin});
	endtask

	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	task automatic set_tap_count(int c);
		@(negedge clk);
		cfg_we     <= 1'b1;
		cfg_index  <= CFG_TAP_COUNT;
		cfg_data   <= CFG_BITS'(c);
		kernel_len = TCNT_BITS'(c);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_kernel(coef_t taps [N_TAPS], int c);
		for (int i = 0; i < N_TAPS; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data  <= taps[i];
			kernel[i] = taps[i];
		end
		set_tap_count(c);
	endtask

	task automatic load_random_kernel(int c);
		coef_t taps [N_TAPS];
		for (int i = 0; i < N_TAPS; i++)
			taps[i] = pick16();
		load_kernel(taps, c);
	endtask

	task automatic test_reset_taps();
		push_sample(16'sh1234, 1'b0);
		push_sample(-16'sd77, 1'b1);
		settle();
	endtask

	task automatic test_extreme_values();
		coef_t taps [N_TAPS];
		for (int i = 0; i < N_TAPS; i++)
			taps[i] = 16'sh8000;
		load_kernel(taps, 7);
		repeat (2) push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b1);
		settle();
		for (int i = 0; i < N_TAPS; i++)
			taps[i] = 16'sh7fff;
		load_kernel(taps, 7);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b1);
		settle();
	endtask

	task automatic test_zero_tap_count();
		load_random_kernel(0);
		push_sample(16'sd1234, 1'b0);
		push_sample(-16'sd5, 1'b1);
		settle();
	endtask

	task automatic test_count_change();
		load_random_kernel(3);
		repeat (3) push_sample(pick16(), 1'b0);
		settle();
		set_tap_count(7);
		push_sample(pick16(), 1'b0);
		push_sample(pick16(), 1'b1);
		settle();
	endtask

	task automatic test_lone_sample();
		for (int c = 1; c <= N_TAPS; c++) begin
			load_random_kernel(c);
			push_sample(pick16(), 1'b1);
			settle();
		end
	endtask

	task automatic test_random(int n_items, int s_idle, int r_idle);
		int sent;
		int len;
		send_idle = s_idle;
		recv_idle = r_idle;
		sent = 0;
		while (sent < n_items) begin
			load_random_kernel($urandom_range(7));
			repeat ($urandom_range(1, 4)) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					push_sample(pick16(), i == len - 1);
				sent += len;
			end
			settle();
		end
	endtask

	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, value %0d final %0b", $time,
					result_word.result_value, result_word.final_result);
			end else begin
				want = pending_results.pop_front();
				if (result_word.result_value !== want.result_value) begin
					errors++;
					$display("%0t: result_value expected %0d actual %0d", $time,
						want.result_value, result_word.result_value);
				end
				if (result_word.final_result !== want.final_result) begin
					errors++;
					$display("%0t: final_result expected %0b actual %0b", $time,
						want.final_result, result_word.final_result);
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < N_TAPS; k++) begin
			kernel[k] = '0;
			window[k] = '0;
		end
		kernel_len = TCNT_RESET;
		seen       = 0;
		send_idle  = 23;
		recv_idle  = 88;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_taps();
		test_extreme_values();
		test_zero_tap_count();
		test_count_change();
		test_lone_sample();
		test_random(105, 23, 88);
		test_random(105, 88, 23);
		test_random(95, 0, 0);
		settle();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb: errors");
		$finish;
	end

endmodule
